FILE: sv/lbc_pkg.sv
// Shared types and codes for the LRU block buffer cache.
// No dependencies; used by the cell, the top level and the testbench.
`default_nettype none
package lbc_pkg;

  // Widest slot index and reference count over the supported parameter range.
  localparam int MAX_POS_W = 6;
  localparam int MAX_REF_W = 16;

  localparam int DEF_NUM_SLOTS = 32;
  localparam int DEF_REF_BITS  = 8;

  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_UNHELD  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Contents of one slot.
  typedef struct packed {
    logic [MAX_POS_W-1:0] slot;
    logic [7:0]           dev;
    logic [31:0]          blk;
    logic [MAX_REF_W-1:0] refs;
    logic                 valid;
  } ent_t;

  // Lookup key broadcast to every cell.
  typedef struct packed {
    logic                 func;
    logic [7:0]           dev;
    logic [31:0]          blk;
    logic [MAX_POS_W-1:0] slot;
  } req_t;

  // Search token handed from cell to cell, most recent first.
  typedef struct packed {
    logic                 cv;
    logic                 found;
    logic [MAX_POS_W-1:0] pos;
    ent_t                 ent;
    logic                 free_found;
    logic [MAX_POS_W-1:0] free_pos;
    logic [MAX_POS_W-1:0] free_slot;
  } carry_t;

  // Update applied to the chain at the end of a search.
  typedef struct packed {
    logic                 wr;
    logic                 shift;
    logic [MAX_POS_W-1:0] pos;
    ent_t                 ent;
  } cmd_t;

endpackage
`default_nettype wire

FILE: sv/lbc_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on nothing; payload widths follow the field list of the block.
`default_nettype none
interface lbc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  device_id;
  logic [31:0] block_number;
  logic [4:0]  slot_in;
  modport source (output valid, func, device_id, block_number, slot_in, input ready);
  modport sink   (input valid, func, device_id, block_number, slot_in, output ready);
endinterface

interface lbc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  slot_out;
  logic        was_valid;
  logic [1:0]  status;
  logic [63:0] hit_total;
  logic [63:0] miss_total;
  modport source (output valid, slot_out, was_valid, status, hit_total, miss_total,
                  input ready);
  modport sink   (input valid, slot_out, was_valid, status, hit_total, miss_total,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/lbc_cell.sv
// One recency position of the cache: holds a slot, checks the passing token.
// Depends on lbc_pkg.
`default_nettype none
module lbc_cell #(
  parameter int NUM_SLOTS = lbc_pkg::DEF_NUM_SLOTS,
  parameter int POS       = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lbc_pkg::req_t   req,
  input  wire lbc_pkg::cmd_t   cmd,
  input  wire lbc_pkg::ent_t   prev_ent,
  input  wire lbc_pkg::carry_t carry_in,
  output lbc_pkg::ent_t        ent_o,
  output lbc_pkg::carry_t      carry_o
);
  localparam logic [lbc_pkg::MAX_POS_W-1:0] MY_POS = lbc_pkg::MAX_POS_W'(POS);
  localparam logic [lbc_pkg::MAX_POS_W-1:0] RST_SLOT =
    lbc_pkg::MAX_POS_W'(NUM_SLOTS - 1 - POS);

  lbc_pkg::ent_t   ent_r, ent_nxt;
  lbc_pkg::carry_t carry_r, carry_nxt;
  logic            match;

  always_comb begin
    if (req.func == lbc_pkg::FUNC_ACQUIRE) begin
      match = (ent_r.dev == req.dev) && (ent_r.blk == req.blk);
    end else begin
      match = (ent_r.slot == req.slot);
    end
  end

  always_comb begin
    carry_nxt = carry_in;
    if (carry_in.cv) begin
      if (!carry_in.found && match) begin
        carry_nxt.found = 1'b1;
        carry_nxt.pos   = MY_POS;
        carry_nxt.ent   = ent_r;
      end
      // later cells are less recent, so the last free one wins
      if (ent_r.refs == '0) begin
        carry_nxt.free_found = 1'b1;
        carry_nxt.free_pos   = MY_POS;
        carry_nxt.free_slot  = ent_r.slot;
      end
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.shift && (MY_POS <= cmd.pos)) begin
      ent_nxt = prev_ent;
    end else if (cmd.wr && (cmd.pos == MY_POS)) begin
      ent_nxt.dev   = cmd.ent.dev;
      ent_nxt.blk   = cmd.ent.blk;
      ent_nxt.refs  = cmd.ent.refs;
      ent_nxt.valid = cmd.ent.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r      <= '{slot: RST_SLOT, dev: '0, blk: '0, refs: '0, valid: 1'b0};
      carry_r.cv <= 1'b0;
    end else begin
      ent_r   <= ent_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign ent_o   = ent_r;
  assign carry_o = carry_r;
endmodule
`default_nettype wire

FILE: sv/lru_block_buffer_cache_top.sv
// Top level of the LRU block buffer cache: request/result channels, chain of
// lbc_cell instances, result logic. Depends on lbc_pkg, lbc_if, lbc_cell.
//
// Usage:
//   in_ch carries requests: func 0 acquires a slot for (device_id,
//   block_number), func 1 releases slot_in. out_ch returns one result per
//   request: slot, hit flag, status and the running hit/miss totals.
//   Both channels transfer when valid and ready are high at a clock edge.
//   The slots sit in a chain of NUM_SLOTS cells ordered by recency, most
//   recent first. A request sends a token down the chain, one cell per
//   cycle; the outcome of the last cell is registered, and the update
//   (count, tags, or move to front with one shift of the chain) is applied
//   when the result is loaded. Only one request is in flight at a time;
//   ready returns in the same cycle that the result is loaded, so a new
//   request is taken only after the previous result has been loaded.
//   A finished result waits in the output register; a new request may be
//   taken while it waits, but the next result holds its update until the
//   receiver has taken the previous one.
//   Reset (rst_n low, synchronous) empties every slot, zeroes tags, counts
//   and totals, and sets recency so slot 0 is least recently used.
`default_nettype none
module lru_block_buffer_cache_top #(
  parameter int NUM_SLOTS = lbc_pkg::DEF_NUM_SLOTS,
  parameter int REF_BITS  = lbc_pkg::DEF_REF_BITS
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lbc_in_if.sink     in_ch,
  lbc_out_if.source  out_ch
);
  localparam int PW = lbc_pkg::MAX_POS_W;
  localparam int RW = lbc_pkg::MAX_REF_W;
  localparam logic [RW-1:0] REF_MAX = RW'((1 << REF_BITS) - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic            tok_r;
  lbc_pkg::req_t   req_r;
  logic [4:0]      sin_r;
  lbc_pkg::carry_t fin_r;
  lbc_pkg::cmd_t   cmd;
  lbc_pkg::carry_t tok_carry;

  lbc_pkg::carry_t carry_w [NUM_SLOTS];
  lbc_pkg::ent_t   ent_w   [NUM_SLOTS];

  logic        out_valid_r;
  logic [4:0]  slot_out_r;
  logic        was_valid_r;
  logic [1:0]  status_r;
  logic [63:0] hit_r, miss_r;

  logic        in_xfer, fin_go;
  logic [4:0]  res_slot;
  logic        res_wv;
  logic [1:0]  res_st;
  logic        hit_inc, miss_inc;
  logic [RW-1:0] ref_dec;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign fin_go      = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    tok_carry    = '0;
    tok_carry.cv = tok_r;
  end

  generate
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      lbc_pkg::ent_t   prev;
      lbc_pkg::carry_t cin;
      if (k == 0) begin : g_head
        assign prev = cmd.ent;
        assign cin  = tok_carry;
      end else begin : g_link
        assign prev = ent_w[k-1];
        assign cin  = carry_w[k-1];
      end
      lbc_cell #(.NUM_SLOTS(NUM_SLOTS), .POS(k)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_r),
        .cmd      (cmd),
        .prev_ent (prev),
        .carry_in (cin),
        .ent_o    (ent_w[k]),
        .carry_o  (carry_w[k])
      );
    end
  endgenerate

  // Outcome of the finished search and the chain update it implies.
  always_comb begin
    cmd      = '0;
    res_slot = 5'd0;
    res_wv   = 1'b0;
    res_st   = lbc_pkg::ST_OK;
    hit_inc  = 1'b0;
    miss_inc = 1'b0;
    ref_dec  = fin_r.ent.refs - RW'(1);
    if (req_r.func == lbc_pkg::FUNC_ACQUIRE) begin
      if (fin_r.found) begin
        res_slot = fin_r.ent.slot[4:0];
        if (fin_r.ent.refs >= REF_MAX) begin
          res_st = lbc_pkg::ST_FULL;
        end else begin
          cmd.wr        = 1'b1;
          cmd.pos       = fin_r.pos;
          cmd.ent       = fin_r.ent;
          cmd.ent.refs  = fin_r.ent.refs + RW'(1);
          cmd.ent.valid = 1'b1;
          res_wv        = fin_r.ent.valid;
          hit_inc       = fin_r.ent.valid;
          miss_inc      = !fin_r.ent.valid;
        end
      end else if (fin_r.free_found) begin
        res_slot      = fin_r.free_slot[4:0];
        cmd.wr        = 1'b1;
        cmd.pos       = fin_r.free_pos;
        cmd.ent.dev   = req_r.dev;
        cmd.ent.blk   = req_r.blk;
        cmd.ent.refs  = RW'(1);
        cmd.ent.valid = 1'b1;
        miss_inc      = 1'b1;
      end else begin
        res_st = lbc_pkg::ST_NO_FREE;
      end
    end else begin
      res_slot = sin_r;
      if ((32'(sin_r) >= NUM_SLOTS) || !fin_r.found || (fin_r.ent.refs == '0)) begin
        res_st = lbc_pkg::ST_UNHELD;
      end else begin
        cmd.pos      = fin_r.pos;
        cmd.ent      = fin_r.ent;
        cmd.ent.refs = ref_dec;
        if (ref_dec == '0) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.wr = 1'b1;
        end
      end
    end
    if (!fin_go) begin
      cmd = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_SCAN;
      S_SCAN:  if (carry_w[NUM_SLOTS-1].cv) state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tok_r       <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= '0;
      miss_r      <= '0;
    end else begin
      state_r <= state_nxt;
      tok_r   <= in_xfer;
      if (fin_go) begin
        out_valid_r <= 1'b1;
        hit_r       <= hit_r + 64'(hit_inc);
        miss_r      <= miss_r + 64'(miss_inc);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r.func <= in_ch.func;
      req_r.dev  <= in_ch.device_id;
      req_r.blk  <= in_ch.block_number;
      req_r.slot <= PW'(in_ch.slot_in);
      sin_r      <= in_ch.slot_in;
    end
    if ((state_r == S_SCAN) && carry_w[NUM_SLOTS-1].cv) begin
      fin_r <= carry_w[NUM_SLOTS-1];
    end
    if (fin_go) begin
      slot_out_r  <= res_slot;
      was_valid_r <= res_wv;
      status_r    <= res_st;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_out   = slot_out_r;
  assign out_ch.was_valid  = was_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.hit_total  = hit_r;
  assign out_ch.miss_total = miss_r;
endmodule
`default_nettype wire

FILE: tb/sv/tb_lru_block_buffer_cache_top.sv
// Testbench for lru_block_buffer_cache_top: directed and random acquire/release
// traffic against a behavioral LRU cache predictor. Depends on lbc_pkg, lbc_if.
`default_nettype none
module tb_lru_block_buffer_cache_top;

  localparam int NSLOT   = 32;
  localparam int RBITS   = 8;
  localparam int REF_TOP = (1 << RBITS) - 1;
  localparam int LIMIT   = 3000000;

  typedef struct packed {
    logic [4:0]  slot;
    logic        hit;
    logic [1:0]  status;
    logic [63:0] hits;
    logic [63:0] misses;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  lbc_in_if  in_ch();
  lbc_out_if out_ch();

  lru_block_buffer_cache_top u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // predictor state
  logic [7:0]  p_dev   [NSLOT];
  logic [31:0] p_blk   [NSLOT];
  int          p_refs  [NSLOT];
  logic        p_valid [NSLOT];
  int          p_rank  [NSLOT];
  logic [63:0] p_hits, p_misses;

  res_t expected_q[$];
  int   errors = 0;
  int   cycles = 0;
  logic hold_off = 1'b0;   // long receiver stall request
  logic [7:0] dev_pool [4] = '{8'h00, 8'h01, 8'h7f, 8'hff};

  task automatic report(input string what, input res_t got, input res_t exp);
    errors++;
    $write("mismatch %s: got slot=%0d hit=%0d st=%0d h=%0d m=%0d",
           what, got.slot, got.hit, got.status, got.hits, got.misses);
    $display(" exp slot=%0d hit=%0d st=%0d h=%0d m=%0d",
             exp.slot, exp.hit, exp.status, exp.hits, exp.misses);
  endtask

  function automatic void cache_reset();
    for (int i = 0; i < NSLOT; i++) begin
      p_dev[i] = '0; p_blk[i] = '0; p_refs[i] = 0; p_valid[i] = 1'b0;
      p_rank[i] = NSLOT - 1 - i;
    end
    p_hits = '0; p_misses = '0;
  endfunction

  function automatic int slot_of_rank(int r);
    for (int i = 0; i < NSLOT; i++) if (p_rank[i] == r) return i;
    return NSLOT;
  endfunction

  function automatic res_t cache_predict(logic fn, logic [7:0] dev, logic [31:0] blk,
                                         logic [4:0] sin);
    res_t r;
    int s, rk;
    logic found;
    r = '0; found = 1'b0;
    if (fn == lbc_pkg::FUNC_ACQUIRE) begin
      for (int k = 0; k < NSLOT && !found; k++) begin
        s = slot_of_rank(k);
        if (s < NSLOT && p_dev[s] == dev && p_blk[s] == blk) begin
          found = 1'b1; r.slot = s[4:0];
          if (p_refs[s] >= REF_TOP) r.status = lbc_pkg::ST_FULL;
          else begin
            p_refs[s]++;
            if (p_valid[s]) begin r.hit = 1'b1; p_hits++; end
            else begin p_valid[s] = 1'b1; p_misses++; end
          end
        end
      end
      for (int k = NSLOT - 1; k >= 0 && !found; k--) begin
        s = slot_of_rank(k);
        if (s < NSLOT && p_refs[s] == 0) begin
          found = 1'b1; r.slot = s[4:0];
          p_dev[s] = dev; p_blk[s] = blk; p_refs[s] = 1; p_valid[s] = 1'b1;
          p_misses++;
        end
      end
      if (!found) r.status = lbc_pkg::ST_NO_FREE;
    end else begin
      r.slot = sin;
      if (int'(sin) >= NSLOT || p_refs[sin] == 0) r.status = lbc_pkg::ST_UNHELD;
      else begin
        p_refs[sin]--;
        if (p_refs[sin] == 0) begin
          rk = p_rank[sin];
          for (int i = 0; i < NSLOT; i++) if (p_rank[i] < rk) p_rank[i]++;
          p_rank[sin] = 0;
        end
      end
    end
    r.hits = p_hits; r.misses = p_misses;
    return r;
  endfunction

  // Send one request: random gap, then hold valid until the transfer.
  // Valid stays up after the transfer until the next gap or the end of the run;
  // ready is low then, so nothing extra transfers.
  task automatic send_req(input logic fn, input logic [7:0] dev, input logic [31:0] blk,
                          input logic [4:0] sin);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.func <= fn; in_ch.device_id <= dev;
    in_ch.block_number <= blk; in_ch.slot_in <= sin;
    expected_q.push_back(cache_predict(fn, dev, blk, sin));
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic acquire(input logic [7:0] dev, input logic [31:0] blk);
    send_req(lbc_pkg::FUNC_ACQUIRE, dev, blk, 5'($urandom()));
  endtask
  task automatic release_slot(input logic [4:0] sin);
    send_req(lbc_pkg::FUNC_RELEASE, 8'($urandom()), $urandom(), sin);
  endtask

  // Result receiver: random stalls per result, plus the long hold-off.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0 || hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        while (hold_off) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Checker: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    res_t got, exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.slot_out, out_ch.was_valid, out_ch.status,
              out_ch.hit_total, out_ch.miss_total};
      if (expected_q.size() == 0) report("unexpected result", got, '0);
      else begin
        exp = expected_q.pop_front();
        if (got.slot != exp.slot)     report("slot", got, exp);
        else if (got.hit != exp.hit)  report("was_valid", got, exp);
        else if (got.status != exp.status) report("status", got, exp);
        else if (got.hits != exp.hits)     report("hit_total", got, exp);
        else if (got.misses != exp.misses) report("miss_total", got, exp);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_lru_block_buffer_cache_top: FAIL");
      $finish;
    end
  end

  // Reset tags (0,0), slot reuse, unheld release.
  task automatic test_directed();
    acquire(8'h00, 32'h0);          // invalid match on reset tag
    acquire(8'h00, 32'h0);          // hit
    acquire(8'hff, 32'hffff_ffff);
    acquire(8'h01, 32'h8000_0001);
    release_slot(5'd31);
    release_slot(5'd31);
    release_slot(5'd0);             // last holder of slot 0 -> move to front
    release_slot(5'd30);
    release_slot(5'd29);
    release_slot(5'd29);
    acquire(8'hff, 32'hffff_ffff);  // stale tag still valid: hit
    release_slot(5'd30);
    release_slot(5'd31);
  endtask

  // Fill every slot, then miss with no free slot, then drain.
  task automatic test_no_free();
    for (int i = 0; i < NSLOT; i++) acquire(8'h10, 32'(i));
    acquire(8'h10, 32'd999);
    for (int i = 0; i < NSLOT; i++) release_slot(i[4:0]);
  endtask

  function automatic int slot_find(logic [7:0] dev, logic [31:0] blk);
    for (int i = 0; i < NSLOT; i++) if (p_dev[i] == dev && p_blk[i] == blk) return i;
    return 0;
  endfunction

  // Drive one slot to the count limit, then back to zero.
  task automatic test_count_full();
    int s;
    for (int i = 0; i < REF_TOP + 1; i++) acquire(8'h22, 32'h1234_5678);
    s = slot_find(8'h22, 32'h1234_5678);
    for (int i = 0; i < REF_TOP + 1; i++) release_slot(5'(s));
  endtask

  // Receiver stalls long while requests keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin repeat (400) @(negedge clk); hold_off = 1'b0; end
      for (int i = 0; i < 6; i++) acquire(8'h33, $urandom_range(0, 7));
    join
    for (int i = 0; i < 6; i++) release_slot(5'($urandom_range(0, 31)));
  endtask

  // Mostly well-formed acquire/release traffic over a small tag pool.
  task automatic test_random();
    int held[$];
    int s;
    for (int n = 0; n < 1400; n++) begin
      case ($urandom_range(0, 9))
        0: release_slot(5'($urandom()));
        1: acquire(8'($urandom()), $urandom());
        2, 3, 4, 5: acquire(dev_pool[$urandom_range(0, 3)], $urandom_range(0, 40));
        default: begin
          if (held.size() == 0) release_slot(5'($urandom()));
          else begin
            s = $urandom_range(0, held.size() - 1);
            release_slot(5'(held[s]));
            held.delete(s);
          end
        end
      endcase
      if (in_ch.func == lbc_pkg::FUNC_ACQUIRE && expected_q.size() > 0 &&
          expected_q[$].status == lbc_pkg::ST_OK)
        held.push_back(expected_q[$].slot);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.func = lbc_pkg::FUNC_ACQUIRE; in_ch.device_id = '0;
    in_ch.block_number = '0; in_ch.slot_in = '0;
    cache_reset();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_no_free();
    test_count_full();
    test_backpressure();
    test_random();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (2 * NSLOT + 10) @(negedge clk);
    if (errors == 0) $display("tb_lru_block_buffer_cache_top: PASS");
    else $display("tb_lru_block_buffer_cache_top: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
